// ----- hdl/dtff_pkg.sv -----
// Package for the discount forward filter: sizes, register indexes, sequencer states
// and the fixed-point helpers (rounding, saturation) shared by the datapath modules.
// No dependencies.
package dtff_pkg;

	localparam int ORDER  = 4;
	localparam int IDX_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam int CELLS  = ORDER * ORDER;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER - 1);

	// divider: one quotient bit per cycle over a 64-bit dividend
	localparam int DIV_BITS = 64;
	localparam int DIV_CW   = $clog2(DIV_BITS + 1);

	localparam logic [1:0] REG_DISCOUNT    = 2'd0;
	localparam logic [1:0] REG_PRIOR_DOF   = 2'd1;
	localparam logic [1:0] REG_PRIOR_SCALE = 2'd2;

	localparam logic [15:0] DISCOUNT_RST    = 16'd63898;
	localparam logic [30:0] PRIOR_DOF_RST   = 31'd65536;
	localparam logic [30:0] PRIOR_SCALE_RST = 31'd65536;
	localparam logic [30:0] ONE_Q16         = 31'd65536;

	typedef struct packed {
		logic               start;
		logic signed [63:0] dividend;
		logic        [30:0] divisor;
	} div_req_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_PRI_MUL, ST_PRI_ACC,
		ST_R_RD, ST_R_DIV, ST_R_WT,
		ST_RF_RD, ST_RF_MUL, ST_RF_ACC, ST_Q_MUL, ST_Q_ACC, ST_F_MUL, ST_F_ACC,
		ST_E, ST_EE_MUL, ST_EE_DIV, ST_EE_WT, ST_D_MUL, ST_D_ACC, ST_S_DIV, ST_S_WT,
		ST_G_DIV, ST_G_WT, ST_M_MUL, ST_M_ACC,
		ST_C_RD, ST_C_MUL1, ST_C_MUL2, ST_C_SUB, ST_C_MUL3, ST_C_DIV, ST_C_WT,
		ST_OUT
	} state_t;

	function automatic logic signed [63:0] sx64(input logic signed [31:0] a);
		return {{32{a[31]}}, a};
	endfunction

	function automatic logic signed [63:0] zx64(input logic [30:0] a);
		return {33'b0, a};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -64'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic [30:0] u31(input logic signed [63:0] x);
		if (x < 64'sd0)
			return '0;
		else if (x > 64'sd2147483647)
			return 31'h7fffffff;
		else
			return x[30:0];
	endfunction

	// Q16.16 product: round half up, then saturate
	function automatic logic signed [31:0] mulq_post(input logic signed [63:0] p);
		logic signed [63:0] x;
		x = (p + 64'sd32768) >>> 16;
		return sat32(x);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] i,
			input logic [IDX_W-1:0] j);
		return ADDR_W'(int'(i) * ORDER + int'(j));
	endfunction

endpackage

// ----- hdl/dtff_mul.sv -----
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on dtff_pkg.
module dtff_mul import dtff_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= 64'(a) * 64'(b);
	end

endmodule

// ----- hdl/dtff_div.sv -----
// Shared restoring divider: signed 64-bit dividend, positive 31-bit divisor,
// quotient truncated toward zero and saturated to 32 bits. Depends on dtff_pkg.
module dtff_div import dtff_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	output logic               done,
	output logic signed [31:0] quot
);

	logic              busy_q, done_q, neg_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [63:0]       num_q;
	logic [30:0]       rem_q, den_q;
	logic [31:0]       sh;
	logic              ge;

	assign sh = {rem_q, num_q[63]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else if (req.start) begin
			neg_q  <= req.dividend[63];
			num_q  <= req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
			rem_q  <= '0;
			den_q  <= req.divisor;
			cnt_q  <= DIV_CW'(DIV_BITS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? 31'(sh - {1'b0, den_q}) : sh[30:0];
			num_q <= {num_q[62:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;

	always_comb begin
		if (!neg_q)
			quot = (num_q[63:31] != '0) ? 32'sh7fffffff : $signed({1'b0, num_q[30:0]});
		else if (num_q > 64'd2147483648)
			quot = 32'sh80000000;
		else
			quot = $signed(32'(~num_q[31:0] + 32'd1));
	end

endmodule

// ----- hdl/discount_tvar_forward_filter_top.sv -----
// Discount forward filter with variance learning, Q16.16, order 4.
// A regressor load is taken while idle. An observation runs up to 38 divisions on the
// shared one-bit-a-step divider, and m_tready stalls can hold the results. The next
// request is taken after the last result is registered. arst_n clears the configuration,
// state and control registers.
module discount_tvar_forward_filter_top import dtff_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // element_index[1:0], sample_value[33:2]
	input  logic         s_tuser,   // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // coef_index, coef_mean, forecast, forecast_error,
	                                // scale_estimate (from bit 0 up)
	output logic         m_tuser,   // bad_variance
	output logic         m_tlast
);

	state_t state_q, state_d;

	logic [15:0] discount_q;
	logic [30:0] prior_dof_q, prior_scale_q;

	logic signed [31:0] regr_q [ORDER];
	logic signed [31:0] means_q [ORDER];
	logic signed [31:0] rf_q [ORDER];
	logic signed [31:0] gain_q [ORDER];
	logic [30:0] dof_q, ssum_q, pscale_q;
	logic        first_q;

	logic [IDX_W-1:0] i_q, j_q, rsel, gsel;
	logic signed [31:0] y_q, q_q, f_q, t_q, e_q, v_q, gi_q;
	logic [15:0] dl_q;
	logic [30:0] sprev_q, nprev_q, dprev_q, n_q, d_q, s_q;
	logic        bad_q;

	logic signed [31:0] cov_mem [CELLS];
	logic signed [31:0] r_mem [CELLS];
	logic signed [31:0] cov_rd_q, r_rd_q;
	logic [ADDR_W-1:0]  addr;
	logic               cov_re, cov_we, r_re, r_we;
	logic signed [31:0] cov_wd, r_wd;

	logic signed [31:0] mul_a, mul_b, mq, cv_sub;
	logic signed [63:0] mul_p;
	div_req_t           div_req;
	logic               div_done;
	logic signed [31:0] div_res;

	logic        o_valid_q, o_bad_q, o_last_q;
	logic [1:0]  o_idx_q;
	logic signed [31:0] o_mean_q, o_f_q, o_e_q;
	logic [30:0] o_s_q;

	logic        in_acc, ij_last, out_free;
	logic [1:0]  in_idx;
	logic signed [31:0] in_val;

	assign in_idx   = s_tdata[1:0];
	assign in_val   = $signed(s_tdata[33:2]);
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign ij_last  = (i_q == LAST_IDX) && (j_q == LAST_IDX);
	assign out_free = !o_valid_q || m_tready;
	assign addr     = cell_addr(i_q, j_q);
	assign rsel     = (state_q == ST_RF_MUL) ? j_q : i_q;
	assign gsel     = (state_q == ST_C_MUL1) ? j_q : i_q;
	assign mq       = mulq_post(mul_p);
	assign cv_sub   = sat32(sx64(r_rd_q) - sx64(mq));

	dtff_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	dtff_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_res)
	);

	always_ff @(posedge clk) begin
		if (cov_we)
			cov_mem[addr] <= cov_wd;
		if (cov_re)
			cov_rd_q <= cov_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (r_we)
			r_mem[addr] <= r_wd;
		if (r_re)
			r_rd_q <= r_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		div_req = '0;
		cov_re  = 1'b0;
		cov_we  = 1'b0;
		cov_wd  = cv_sub;
		r_re    = 1'b0;
		r_we    = 1'b0;
		r_wd    = div_res;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser)
					state_d = first_q ? ST_PRI_MUL : ST_R_RD;
			end
			ST_PRI_MUL: begin
				mul_a   = $signed({1'b0, prior_dof_q});
				mul_b   = $signed({1'b0, prior_scale_q});
				state_d = ST_PRI_ACC;
			end
			ST_PRI_ACC: state_d = ST_R_RD;
			ST_R_RD: begin
				cov_re  = 1'b1;
				state_d = ST_R_DIV;
			end
			ST_R_DIV: begin
				div_req.start   = 1'b1;
				div_req.divisor = {15'b0, dl_q};
				if (!first_q)
					div_req.dividend = sx64(cov_rd_q) <<< 16;
				else if (i_q == j_q)
					div_req.dividend = zx64(prior_scale_q) <<< 16;
				else
					div_req.dividend = '0;
				state_d = ST_R_WT;
			end
			ST_R_WT: begin
				if (div_done) begin
					r_we    = 1'b1;
					state_d = ij_last ? ST_RF_RD : ST_R_RD;
				end
			end
			ST_RF_RD: begin
				r_re    = 1'b1;
				state_d = ST_RF_MUL;
			end
			ST_RF_MUL: begin
				mul_a   = r_rd_q;
				mul_b   = regr_q[rsel];
				state_d = ST_RF_ACC;
			end
			ST_RF_ACC: state_d = (j_q == LAST_IDX) ? ST_Q_MUL : ST_RF_RD;
			ST_Q_MUL: begin
				mul_a   = regr_q[rsel];
				mul_b   = t_q;
				state_d = ST_Q_ACC;
			end
			ST_Q_ACC: state_d = ST_F_MUL;
			ST_F_MUL: begin
				mul_a   = regr_q[rsel];
				mul_b   = means_q[i_q];
				state_d = ST_F_ACC;
			end
			ST_F_ACC: state_d = (i_q == LAST_IDX) ? ST_E : ST_RF_RD;
			ST_E: begin
				if (q_q[31] || q_q == '0)
					state_d = ST_OUT;
				else
					state_d = ST_EE_MUL;
			end
			ST_EE_MUL: begin
				mul_a   = e_q;
				mul_b   = e_q;
				state_d = ST_EE_DIV;
			end
			ST_EE_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = sx64(mq) <<< 16;
				div_req.divisor  = q_q[30:0];
				state_d = ST_EE_WT;
			end
			ST_EE_WT: if (div_done) state_d = ST_D_MUL;
			ST_D_MUL: begin
				mul_a   = $signed({1'b0, sprev_q});
				mul_b   = t_q;
				state_d = ST_D_ACC;
			end
			ST_D_ACC: state_d = ST_S_DIV;
			ST_S_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = zx64(d_q) <<< 16;
				div_req.divisor  = n_q;
				state_d = ST_S_WT;
			end
			ST_S_WT: if (div_done) state_d = ST_G_DIV;
			ST_G_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = sx64(rf_q[i_q]) <<< 16;
				div_req.divisor  = q_q[30:0];
				state_d = ST_G_WT;
			end
			ST_G_WT: if (div_done) state_d = ST_M_MUL;
			ST_M_MUL: begin
				mul_a   = gain_q[gsel];
				mul_b   = e_q;
				state_d = ST_M_ACC;
			end
			ST_M_ACC: state_d = (i_q == LAST_IDX) ? ST_C_RD : ST_G_DIV;
			ST_C_RD: begin
				r_re    = 1'b1;
				state_d = ST_C_MUL1;
			end
			ST_C_MUL1: begin
				mul_a   = gi_q;
				mul_b   = gain_q[gsel];
				state_d = ST_C_MUL2;
			end
			ST_C_MUL2: begin
				mul_a   = mq;
				mul_b   = q_q;
				state_d = ST_C_SUB;
			end
			ST_C_SUB: begin
				if (sprev_q != '0) begin
					state_d = ST_C_MUL3;
				end else begin
					cov_we  = 1'b1;
					state_d = ij_last ? ST_OUT : ST_C_RD;
				end
			end
			ST_C_MUL3: begin
				mul_a   = v_q;
				mul_b   = $signed({1'b0, s_q});
				state_d = ST_C_DIV;
			end
			ST_C_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = mul_p;
				div_req.divisor  = sprev_q;
				state_d = ST_C_WT;
			end
			ST_C_WT: begin
				if (div_done) begin
					cov_we  = 1'b1;
					cov_wd  = div_res;
					state_d = ij_last ? ST_OUT : ST_C_RD;
				end
			end
			ST_OUT: begin
				if (out_free && i_q == LAST_IDX)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// walk of the covariance cells, row by row
	logic cell_step;
	assign cell_step = (state_q == ST_R_WT && div_done) ||
		(state_q == ST_C_WT && div_done) ||
		(state_q == ST_C_SUB && sprev_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q    <= DISCOUNT_RST;
			prior_dof_q   <= PRIOR_DOF_RST;
			prior_scale_q <= PRIOR_SCALE_RST;
			for (int k = 0; k < ORDER; k++) begin
				regr_q[k]  <= '0;
				means_q[k] <= '0;
			end
			dof_q    <= '0;
			ssum_q   <= '0;
			pscale_q <= '0;
			first_q  <= 1'b1;
			i_q      <= '0;
			j_q      <= '0;
			bad_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DISCOUNT:    discount_q    <= cfg_wdata[15:0];
					REG_PRIOR_DOF:   prior_dof_q   <= cfg_wdata;
					REG_PRIOR_SCALE: prior_scale_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cell_step) begin
				if (ij_last) begin
					i_q <= '0;
					j_q <= '0;
				end else if (j_q == LAST_IDX) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && !s_tuser && 32'(in_idx) < ORDER)
						regr_q[IDX_W'(in_idx)] <= in_val;
					if (in_acc && s_tuser) begin
						i_q   <= '0;
						j_q   <= '0;
						bad_q <= 1'b0;
					end
				end
				ST_RF_ACC: begin
					if (j_q == LAST_IDX)
						j_q <= '0;
					else
						j_q <= j_q + 1'b1;
				end
				ST_F_ACC: i_q <= (i_q == LAST_IDX) ? '0 : i_q + 1'b1;
				ST_E: begin
					if (q_q[31] || q_q == '0)
						bad_q <= 1'b1;
				end
				ST_M_ACC: begin
					means_q[i_q] <= sat32(sx64(means_q[i_q]) + sx64(mq));
					i_q <= (i_q == LAST_IDX) ? '0 : i_q + 1'b1;
				end
				ST_OUT: begin
					if (out_free)
						i_q <= (i_q == LAST_IDX) ? '0 : i_q + 1'b1;
				end
				default: ;
			endcase
			// commit the step once the last covariance cell is written
			if (cell_step && ij_last && state_q != ST_R_WT) begin
				dof_q    <= n_q;
				ssum_q   <= d_q;
				pscale_q <= s_q;
				first_q  <= 1'b0;
			end
		end
	end

	// step payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser) begin
					y_q     <= in_val;
					dl_q    <= (discount_q == '0) ? 16'd1 : discount_q;
					sprev_q <= first_q ? prior_scale_q : pscale_q;
					nprev_q <= first_q ? prior_dof_q : dof_q;
					dprev_q <= ssum_q;
				end
			end
			ST_PRI_ACC: dprev_q <= u31(sx64(mq));
			ST_R_WT: begin
				if (div_done && ij_last) begin
					q_q <= $signed({1'b0, sprev_q});
					f_q <= '0;
					t_q <= '0;
				end
			end
			ST_RF_ACC: begin
				t_q <= sat32(sx64(t_q) + sx64(mq));
				if (j_q == LAST_IDX)
					rf_q[i_q] <= sat32(sx64(t_q) + sx64(mq));
			end
			ST_Q_ACC: q_q <= sat32(sx64(q_q) + sx64(mq));
			ST_F_ACC: begin
				f_q <= sat32(sx64(f_q) + sx64(mq));
				t_q <= '0;
			end
			ST_E: begin
				e_q <= sat32(sx64(y_q) - sx64(f_q));
				s_q <= sprev_q;
				n_q <= u31(zx64(nprev_q) + zx64(ONE_Q16));
			end
			ST_EE_WT: if (div_done) t_q <= div_res;
			ST_D_ACC: d_q <= u31(zx64(dprev_q) + sx64(mq));
			ST_S_WT: if (div_done) s_q <= u31(sx64(div_res));
			ST_G_WT: if (div_done) gain_q[i_q] <= div_res;
			ST_C_RD: gi_q <= gain_q[gsel];
			ST_C_SUB: v_q <= cv_sub;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			o_valid_q <= 1'b1;
		end else if (m_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			o_idx_q  <= 2'(i_q);
			o_mean_q <= means_q[i_q];
			o_f_q    <= f_q;
			o_e_q    <= e_q;
			o_s_q    <= s_q;
			o_bad_q  <= bad_q;
			o_last_q <= (i_q == LAST_IDX);
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {7'b0, o_s_q, o_e_q, o_f_q, o_mean_q, o_idx_q};
	assign m_tuser  = o_bad_q;
	assign m_tlast  = o_last_q;

endmodule
